// ----- design/aso_pkg.sv -----
// ----------------------------------------------------------------------------
// aso_pkg
// Shared types and constants for the screen orientation debounce block.
// ----------------------------------------------------------------------------
package aso_pkg;

    localparam int unsigned AXIS_W    = 16;
    localparam int unsigned MAG_W     = AXIS_W + 1;
    localparam int unsigned TILT_W    = 16;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned S_DATA_W  = 2 * AXIS_W;
    localparam int unsigned M_DATA_W  = 8;

    typedef logic [1:0] orient_t;

    localparam orient_t ORIENT_PORTRAIT  = 2'd0;
    localparam orient_t ORIENT_LAND_XNEG = 2'd1;
    localparam orient_t ORIENT_INVERTED  = 2'd2;
    localparam orient_t ORIENT_LAND_XPOS = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MIN_TILT     = 2'd0;
    localparam cfg_idx_t REG_DOMINANCE    = 2'd1;
    localparam cfg_idx_t REG_STABLE_COUNT = 2'd2;

    localparam logic [TILT_W-1:0]  MIN_TILT_RESET  = 16'd3686;
    localparam logic [TILT_W-1:0]  DOMINANCE_RESET = 16'd1311;
    localparam logic [COUNT_W-1:0] STABLE_RESET    = 4'd4;

    // Outcome of classifying one sample.
    typedef struct packed {
        logic    usable;
        orient_t orient;
    } class_t;

endpackage

// ----- design/accel_screen_orientation_debounce_unit.sv -----
// ----------------------------------------------------------------------------
// accel_screen_orientation_debounce_unit
// Screen orientation from accelerometer X/Y samples, with debounce.
// ----------------------------------------------------------------------------
// One result word is produced for every sample word. It is loaded into the
// result register from the input register, and a new sample can be taken in
// every cycle while the result side takes its words. A sample is held in an
// input register; classification and the debounce update sit in a single
// combinational step between that register and the result register, so the
// debounce state is brought up to date in the same cycle as each sample moves
// on. While a result waits to be taken the input register can still take one more
// sample; after that the input stalls until the result side takes its word.
// Configuration writes take effect on the next sample.
module accel_screen_orientation_debounce_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x [15:0], accel_y [31:16]
    input  logic [aso_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // orientation [1:0], changed [2], zero [7:3]
    output logic [aso_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                               cfg_we,
    input  aso_pkg::cfg_idx_t                  cfg_index,
    input  logic [aso_pkg::CFG_W-1:0]          cfg_data
);
    import aso_pkg::*;

    logic                     in_valid_reg;
    logic [AXIS_W-1:0]        x_reg;
    logic [AXIS_W-1:0]        y_reg;
    logic                     out_valid_reg;
    orient_t                  orient_reg;
    logic                     changed_reg;
    logic                     advance;
    logic                     take;

    logic [TILT_W-1:0]        min_tilt_reg;
    logic [TILT_W-1:0]        margin_reg;
    logic [COUNT_W-1:0]       stable_reg;

    class_t                   cls;
    orient_t                  orient_next;
    logic                     changed_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tilt_reg <= MIN_TILT_RESET;
            margin_reg   <= DOMINANCE_RESET;
            stable_reg   <= STABLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_TILT:     min_tilt_reg <= cfg_data;
                REG_DOMINANCE:    margin_reg   <= cfg_data;
                REG_STABLE_COUNT: stable_reg   <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= s_tdata[AXIS_W-1:0];
            y_reg <= s_tdata[S_DATA_W-1:AXIS_W];
        end
        if (advance)
        begin
            orient_reg  <= orient_next;
            changed_reg <= changed_next;
        end
    end

    aso_classify u_classify
    (
        .accel_x          (x_reg),
        .accel_y          (y_reg),
        .min_tilt         (min_tilt_reg),
        .dominance_margin (margin_reg),
        .result           (cls)
    );

    aso_debounce u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .cls          (cls),
        .stable_count (stable_reg),
        .orient_next  (orient_next),
        .changed_next (changed_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - 3)'(0), changed_reg, orient_reg};

endmodule

// ----- design/aso_classify.sv -----
// ----------------------------------------------------------------------------
// aso_classify
// Turns one X/Y sample into a candidate orientation, or marks it unusable.
// ----------------------------------------------------------------------------
module aso_classify
(
    input  logic signed [aso_pkg::AXIS_W-1:0] accel_x,
    input  logic signed [aso_pkg::AXIS_W-1:0] accel_y,
    input  logic        [aso_pkg::TILT_W-1:0] min_tilt,
    input  logic        [aso_pkg::TILT_W-1:0] dominance_margin,
    output aso_pkg::class_t                   result
);
    import aso_pkg::*;

    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] tilt_ext;
    logic [MAG_W-1:0] margin_ext;
    logic             x_wins;

    // Magnitudes are one bit wider so that the most negative count gives 32768.
    assign ax = accel_x[AXIS_W-1] ? (~{accel_x[AXIS_W-1], accel_x} + MAG_W'(1))
                                  : {1'b0, accel_x};
    assign ay = accel_y[AXIS_W-1] ? (~{accel_y[AXIS_W-1], accel_y} + MAG_W'(1))
                                  : {1'b0, accel_y};

    assign x_wins     = ax > ay;
    assign diff       = x_wins ? (ax - ay) : (ay - ax);
    assign tilt_ext   = {1'b0, min_tilt};
    assign margin_ext = {1'b0, dominance_margin};

    always_comb
    begin
        result.usable = !((ax < tilt_ext) && (ay < tilt_ext)) && !(diff < margin_ext);
        if (x_wins)
        begin
            result.orient = accel_x[AXIS_W-1] ? ORIENT_LAND_XNEG : ORIENT_LAND_XPOS;
        end
        else
        begin
            result.orient = accel_y[AXIS_W-1] ? ORIENT_PORTRAIT : ORIENT_INVERTED;
        end
    end

endmodule

// ----- design/aso_debounce.sv -----
// ----------------------------------------------------------------------------
// aso_debounce
// Candidate tracking and commit of the orientation, one sample per step.
// ----------------------------------------------------------------------------
module aso_debounce
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  aso_pkg::class_t                cls,
    input  logic [aso_pkg::COUNT_W-1:0]    stable_count,
    output aso_pkg::orient_t               orient_next,
    output logic                           changed_next
);
    import aso_pkg::*;

    orient_t              current_reg;
    orient_t              current_next;
    orient_t              cand_reg;
    orient_t              cand_next;
    logic                 cand_valid_reg;
    logic                 cand_valid_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    always_comb
    begin
        current_next    = current_reg;
        cand_next       = cand_reg;
        cand_valid_next = cand_valid_reg;
        count_next      = count_reg;
        changed_next    = 1'b0;
        if (cls.usable)
        begin
            if (!cand_valid_reg || (cls.orient != cand_reg))
            begin
                cand_valid_next = 1'b1;
                cand_next       = cls.orient;
                count_next      = COUNT_W'(1);
            end
            else if (count_reg < stable_count)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            else if (cls.orient != current_reg)
            begin
                // The candidate has held long enough and appeared once more.
                current_next = cls.orient;
                changed_next = 1'b1;
            end
        end
    end

    assign orient_next = current_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg    <= ORIENT_PORTRAIT;
            cand_reg       <= ORIENT_PORTRAIT;
            cand_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            current_reg    <= current_next;
            cand_reg       <= cand_next;
            cand_valid_reg <= cand_valid_next;
            count_reg      <= count_next;
        end
    end

endmodule
